[hdl/dpm_pkg.sv]
// Shared constants for the differential drive PID move controller.
package dpm_pkg;

    localparam int CNT_W   = 16;
    localparam int DIST_W  = 16;
    localparam int PULSE_W = 11;
    localparam int E_W     = CNT_W + 1;
    localparam int D_W     = E_W + 1;
    localparam int S_W     = 32;
    localparam int ACC_W   = 41;
    localparam int T10_W   = ACC_W + 4;
    localparam int PROD_W  = 24;
    localparam int CORR_W  = 8;
    localparam int SPD_W   = 10;
    localparam int GAIN_W  = 8;
    localparam int STEP_W  = $clog2(GAIN_W);

    localparam logic [GAIN_W-1:0] GAIN_I_Q8 = 8'd119;
    localparam logic [GAIN_W-1:0] GAIN_D_Q8 = 8'd135;

    localparam logic [PULSE_W-1:0] STOP_PULSE = 11'd1500;
    localparam int SPEED_SLOW = 130;
    localparam int SPEED_FAST = 200;
    localparam int CORR_LIMIT = 70;
    localparam int CLAMP_EDGE = (CORR_LIMIT + 1) * 1024;

endpackage

[hdl/dpm_mac.sv]
// Bit-serial multiply of the integral and derivative terms by their Q8 gains, summed with the error at unit gain.
module dpm_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [dpm_pkg::E_W-1:0]     i_e,
    input  logic signed [dpm_pkg::S_W-1:0]     i_s,
    input  logic signed [dpm_pkg::D_W-1:0]     i_d,
    output logic signed [dpm_pkg::ACC_W-1:0]   o_acc,
    output logic                               o_done
);

    logic signed [dpm_pkg::ACC_W-1:0]  r_acc;
    logic signed [dpm_pkg::ACC_W-1:0]  n_acc;
    logic [dpm_pkg::STEP_W-1:0]        r_cnt;
    logic                              r_busy;
    logic                              r_done;
    logic signed [dpm_pkg::ACC_W-1:0]  w_s_term;
    logic signed [dpm_pkg::ACC_W-1:0]  w_d_term;

    always_comb begin
        w_s_term = '0;
        w_d_term = '0;
        if (dpm_pkg::GAIN_I_Q8[r_cnt]) begin
            w_s_term = {{(dpm_pkg::ACC_W-dpm_pkg::S_W){i_s[dpm_pkg::S_W-1]}}, i_s};
        end
        if (dpm_pkg::GAIN_D_Q8[r_cnt]) begin
            w_d_term = {{(dpm_pkg::ACC_W-dpm_pkg::D_W){i_d[dpm_pkg::D_W-1]}}, i_d};
        end
        n_acc = (r_acc <<< 1) + w_s_term + w_d_term;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{(dpm_pkg::ACC_W-dpm_pkg::E_W){i_e[dpm_pkg::E_W-1]}}, i_e};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= dpm_pkg::STEP_W'(dpm_pkg::GAIN_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

[hdl/differential_drive_pid_move.sv]
// Top level of the differential drive PID move controller.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   input    | i_in_valid / o_in_ready    | i_left_count, i_right_count
//   result   | o_out_valid / i_out_ready  | o_right_pulse, o_left_pulse, o_arrived
//   config   | i_cfg_valid / o_cfg_ready  | i_move_distance
//
// A driving tick runs calc, compare, the multiplier (eight gain bits, then done), scale,
// clamp and write; an arrival tick goes from compare straight to write.
// The next input is taken in idle, which follows the write.
// The result register frees the input side: a new tick is taken while a result waits,
// and the write cycle holds until the result register is free.
// Reset clears move_distance, error_sum, previous_error and last_travel.
module differential_drive_pid_move (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dpm_pkg::CNT_W-1:0]          i_left_count,
    input  logic [dpm_pkg::CNT_W-1:0]          i_right_count,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dpm_pkg::PULSE_W-1:0]        o_right_pulse,
    output logic [dpm_pkg::PULSE_W-1:0]        o_left_pulse,
    output logic                               o_arrived,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic signed [dpm_pkg::DIST_W-1:0]  i_move_distance
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CALC  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_MAC   = 7'b0001000,
        S_SCALE = 7'b0010000,
        S_CLAMP = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    localparam int P_W = dpm_pkg::PROD_W;

    t_state r_state;
    t_state n_state;

    logic signed [dpm_pkg::DIST_W-1:0]  r_move_distance;
    logic signed [dpm_pkg::S_W-1:0]     r_error_sum;
    logic signed [dpm_pkg::E_W-1:0]     r_prev_error;
    logic [dpm_pkg::CNT_W-1:0]          r_last_travel;

    logic [dpm_pkg::CNT_W-1:0]          r_left;
    logic [dpm_pkg::CNT_W-1:0]          r_right;
    logic signed [dpm_pkg::E_W-1:0]     r_e;
    logic signed [dpm_pkg::D_W-1:0]     r_d;
    logic signed [dpm_pkg::S_W-1:0]     r_sum;
    logic [dpm_pkg::CNT_W-1:0]          r_travel;
    logic [P_W-1:0]                     r_arr_lhs;
    logic [P_W-1:0]                     r_mag100;
    logic [P_W-1:0]                     r_t145;
    logic [P_W-1:0]                     r_mag90;
    logic [P_W-1:0]                     r_mag5;
    logic                               r_arrive;
    logic                               r_slow;
    logic signed [dpm_pkg::T10_W-1:0]   r_t10;
    logic signed [dpm_pkg::CORR_W-1:0]  r_corr;

    logic                               r_out_valid;
    logic [dpm_pkg::PULSE_W-1:0]        r_right_pulse;
    logic [dpm_pkg::PULSE_W-1:0]        r_left_pulse;
    logic                               r_arrived;

    logic [dpm_pkg::DIST_W-1:0]         w_mag;
    logic signed [dpm_pkg::E_W-1:0]     w_e;
    logic [dpm_pkg::CNT_W:0]            w_lr_sum;
    logic signed [dpm_pkg::S_W:0]       w_sum_wide;
    logic signed [dpm_pkg::S_W-1:0]     w_sum_sat;
    logic                               w_arrive;
    logic                               w_mac_start;
    logic                               w_mac_done;
    logic signed [dpm_pkg::ACC_W-1:0]   w_acc;
    logic signed [dpm_pkg::T10_W-1:0]   w_acc_x;
    logic signed [dpm_pkg::T10_W-1:0]   w_clamp_edge;
    logic signed [17:0]                 w_low;
    logic signed [17:0]                 w_low_adj;
    logic signed [dpm_pkg::CORR_W-1:0]  w_corr;
    logic signed [dpm_pkg::SPD_W-1:0]   w_speed;
    logic signed [dpm_pkg::SPD_W-1:0]   w_corr_x;
    logic signed [dpm_pkg::SPD_W-1:0]   w_right_v;
    logic signed [dpm_pkg::SPD_W-1:0]   w_left_v;
    logic signed [dpm_pkg::PULSE_W:0]   w_stop_x;
    logic signed [dpm_pkg::PULSE_W:0]   w_right_p;
    logic signed [dpm_pkg::PULSE_W:0]   w_left_p;
    logic                               w_out_free;
    logic                               w_write;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_write     = (r_state == S_DONE) && w_out_free;
    assign w_mac_start = (r_state == S_CMP) && !w_arrive;

    assign w_mag = r_move_distance[dpm_pkg::DIST_W-1] ? (~r_move_distance + 1'b1)
                                                     : r_move_distance;

    assign w_e      = $signed({1'b0, r_left}) - $signed({1'b0, r_right});
    assign w_lr_sum = {1'b0, r_left} + {1'b0, r_right};

    always_comb begin
        w_sum_wide = {r_error_sum[dpm_pkg::S_W-1], r_error_sum}
                   + {{(dpm_pkg::S_W+1-dpm_pkg::E_W){r_prev_error[dpm_pkg::E_W-1]}},
                      r_prev_error};
        if (w_sum_wide[dpm_pkg::S_W] != w_sum_wide[dpm_pkg::S_W-1]) begin
            w_sum_sat = w_sum_wide[dpm_pkg::S_W] ? {1'b1, {(dpm_pkg::S_W-1){1'b0}}}
                                                  : {1'b0, {(dpm_pkg::S_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_wide[dpm_pkg::S_W-1:0];
        end
    end

    assign w_arrive = (r_arr_lhs >= r_mag100);

    assign w_acc_x = {{(dpm_pkg::T10_W-dpm_pkg::ACC_W){w_acc[dpm_pkg::ACC_W-1]}}, w_acc};
    assign w_clamp_edge = dpm_pkg::T10_W'(dpm_pkg::CLAMP_EDGE);

    always_comb begin
        w_low     = r_t10[17:0];
        w_low_adj = w_low + (w_low[17] ? 18'sd1023 : 18'sd0);
        if (r_t10 >= w_clamp_edge) begin
            w_corr = dpm_pkg::CORR_W'(dpm_pkg::CORR_LIMIT);
        end else if (r_t10 <= -w_clamp_edge) begin
            w_corr = -dpm_pkg::CORR_W'(dpm_pkg::CORR_LIMIT);
        end else begin
            w_corr = w_low_adj[17:10];
        end
    end

    always_comb begin
        w_speed   = r_slow ? dpm_pkg::SPD_W'(dpm_pkg::SPEED_SLOW)
                           : dpm_pkg::SPD_W'(dpm_pkg::SPEED_FAST);
        w_corr_x  = {{(dpm_pkg::SPD_W-dpm_pkg::CORR_W){r_corr[dpm_pkg::CORR_W-1]}}, r_corr};
        w_right_v = w_speed + w_corr_x;
        w_left_v  = w_speed - w_corr_x;
        w_stop_x  = $signed({1'b0, dpm_pkg::STOP_PULSE});
        if (r_move_distance[dpm_pkg::DIST_W-1]) begin
            w_right_p = w_stop_x - {{(dpm_pkg::PULSE_W+1-dpm_pkg::SPD_W){w_right_v[dpm_pkg::SPD_W-1]}},
                                    w_right_v};
            w_left_p  = w_stop_x - {{(dpm_pkg::PULSE_W+1-dpm_pkg::SPD_W){w_left_v[dpm_pkg::SPD_W-1]}},
                                    w_left_v};
        end else begin
            w_right_p = w_stop_x + {{(dpm_pkg::PULSE_W+1-dpm_pkg::SPD_W){w_right_v[dpm_pkg::SPD_W-1]}},
                                    w_right_v};
            w_left_p  = w_stop_x + {{(dpm_pkg::PULSE_W+1-dpm_pkg::SPD_W){w_left_v[dpm_pkg::SPD_W-1]}},
                                    w_left_v};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = w_arrive ? S_DONE : S_MAC;
            end
            S_MAC: begin
                if (w_mac_done) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_move_distance <= '0;
            r_error_sum     <= '0;
            r_prev_error    <= '0;
            r_last_travel   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_move_distance <= i_move_distance;
            end
            if (w_write) begin
                r_out_valid <= 1'b1;
                if (r_arrive) begin
                    r_error_sum   <= '0;
                    r_prev_error  <= '0;
                    r_last_travel <= '0;
                end else begin
                    r_error_sum   <= r_sum;
                    r_prev_error  <= r_e;
                    r_last_travel <= r_travel;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_left  <= i_left_count;
            r_right <= i_right_count;
        end
        if (r_state == S_CALC) begin
            r_e       <= w_e;
            r_d       <= {w_e[dpm_pkg::E_W-1], w_e} - {r_prev_error[dpm_pkg::E_W-1], r_prev_error};
            r_sum     <= w_sum_sat;
            r_travel  <= w_lr_sum[dpm_pkg::CNT_W:1];
            r_arr_lhs <= P_W'({1'b0, r_last_travel} + 17'd2) * P_W'(145);
            r_mag100  <= P_W'(w_mag) * P_W'(100);
        end
        if (r_state == S_CMP) begin
            r_arrive <= w_arrive;
            r_t145   <= P_W'(r_travel) * P_W'(145);
            r_mag90  <= P_W'(w_mag) * P_W'(90);
            r_mag5   <= P_W'(w_mag) * P_W'(5);
        end
        if (r_state == S_SCALE) begin
            r_t10  <= (w_acc_x <<< 3) + (w_acc_x <<< 1);
            r_slow <= (r_t145 >= r_mag90) || (r_t145 <= r_mag5);
        end
        if (r_state == S_CLAMP) begin
            r_corr <= w_corr;
        end
        if (w_write) begin
            if (r_arrive) begin
                r_right_pulse <= dpm_pkg::STOP_PULSE;
                r_left_pulse  <= dpm_pkg::STOP_PULSE;
                r_arrived     <= 1'b1;
            end else begin
                r_right_pulse <= w_right_p[dpm_pkg::PULSE_W-1:0];
                r_left_pulse  <= w_left_p[dpm_pkg::PULSE_W-1:0];
                r_arrived     <= 1'b0;
            end
        end
    end

    dpm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_e     (r_e),
        .i_s     (r_sum),
        .i_d     (r_d),
        .o_acc   (w_acc),
        .o_done  (w_mac_done)
    );

    assign o_out_valid   = r_out_valid;
    assign o_right_pulse = r_right_pulse;
    assign o_left_pulse  = r_left_pulse;
    assign o_arrived     = r_arrived;

`ifndef SYNTHESIS
    a_arrive_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_arrived) |->
            (o_right_pulse == dpm_pkg::STOP_PULSE) && (o_left_pulse == dpm_pkg::STOP_PULSE))
        else $error("arrival result without stop pulses");

    a_drive_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_arrived) |->
            ((12'(o_right_pulse) + 12'(o_left_pulse) == 12'(2 * 1500 + 2 * dpm_pkg::SPEED_SLOW)) ||
             (12'(o_right_pulse) + 12'(o_left_pulse) == 12'(2 * 1500 + 2 * dpm_pkg::SPEED_FAST)) ||
             (12'(o_right_pulse) + 12'(o_left_pulse) == 12'(2 * 1500 - 2 * dpm_pkg::SPEED_SLOW)) ||
             (12'(o_right_pulse) + 12'(o_left_pulse) == 12'(2 * 1500 - 2 * dpm_pkg::SPEED_FAST))))
        else $error("wheel pulses do not balance around base speed");

    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transfer taken while a tick is in work");

    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == S_MAC))
        else $error("multiplier finished outside its wait state");
`endif

endmodule
